// ===== hw/rtl/sheared_ellipse_fill_spans_core_assert.svh =====
// Assertion macros for the sheared ellipse span rasterizer.
`ifndef SHEARED_ELLIPSE_FILL_SPANS_CORE_ASSERT_SVH
`define SHEARED_ELLIPSE_FILL_SPANS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SEFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SEFS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("assertion failed");
`else
`define SEFS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SEFS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/sefs_pkg.sv =====
// Shared types and constants for the sheared ellipse span rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package sefs_pkg;

	localparam int MAX_RADIUS_DEF = 31;
	localparam int HW_BITS = 7;

	localparam logic [10:0] CANVAS_LIMIT = 11'd1024;
	localparam logic [10:0] CANVAS_W_RST = 11'd128;
	localparam logic [10:0] CANVAS_H_RST = 11'd64;

	localparam logic REG_CANVAS_WIDTH  = 1'b0;
	localparam logic REG_CANVAS_HEIGHT = 1'b1;

	typedef struct packed {
		logic               degen;
		logic signed [11:0] cx;
		logic signed [11:0] cy;
		logic [4:0]         ry;
		logic [9:0]         ry2;
		logic [13:0]        rx2;
		logic signed [8:0]  sh;
		logic               val;
	} cmd_t;

	typedef struct packed {
		logic [9:0] row;
		logic [9:0] lo;
		logic [9:0] hi;
		logic       valid;
		logic       value;
		logic       last;
	} span_t;

	typedef struct packed {
		logic [10:0] width;
		logic [10:0] height;
	} canvas_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sheared_ellipse_fill_spans_core.sv =====
// Top level of the sheared ellipse span rasterizer.
// The back end takes the next command only from idle, once the last span of the one before is pushed.
// Row rate is set by the 7-step half-width search, one bit per cycle in the back end.
// Reset clears both queues and the row walker and loads canvas 128 x 64.
`timescale 1ns / 1ps
`default_nettype none
`include "sheared_ellipse_fill_spans_core_assert.svh"
module sheared_ellipse_fill_spans_core #(
	parameter int MAX_RADIUS = sefs_pkg::MAX_RADIUS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [10:0]        cfg_data,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [11:0] center_x,
	input  wire logic signed [11:0] center_y,
	input  wire logic signed [7:0]  radius_x,
	input  wire logic signed [5:0]  radius_y,
	input  wire logic signed [8:0]  shear_q8,
	input  wire logic               pixel_value,
	input  wire logic               pop,
	output logic                    empty,
	output logic [9:0]              row_y,
	output logic [9:0]              span_start,
	output logic [9:0]              span_end,
	output logic                    span_valid,
	output logic                    span_value,
	output logic                    last_span
);

	localparam int CMD_W  = $bits(sefs_pkg::cmd_t);
	localparam int SPAN_W = $bits(sefs_pkg::span_t);

	logic [10:0]       width_q;
	logic [10:0]       height_q;
	sefs_pkg::canvas_t canvas;
	sefs_pkg::cmd_t    cmd_front;
	sefs_pkg::cmd_t    cmd_head;
	logic [CMD_W-1:0]  cmd_head_vec;
	logic              cmd_empty;
	logic              cmd_pop;
	sefs_pkg::span_t   span_back;
	sefs_pkg::span_t   span_head;
	logic [SPAN_W-1:0] span_head_vec;
	logic              span_push;
	logic              span_full;
	logic              span_on_canvas;
	logic              span_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sefs_pkg::CANVAS_W_RST;
			height_q <= sefs_pkg::CANVAS_H_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sefs_pkg::REG_CANVAS_WIDTH:  width_q  <= cfg_data;
				sefs_pkg::REG_CANVAS_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		canvas.width  = (width_q > sefs_pkg::CANVAS_LIMIT) ? sefs_pkg::CANVAS_LIMIT : width_q;
		canvas.height = (height_q > sefs_pkg::CANVAS_LIMIT) ? sefs_pkg::CANVAS_LIMIT : height_q;
	end

	sefs_front #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_front (
		.center_x(center_x),
		.center_y(center_y),
		.radius_x(radius_x),
		.radius_y(radius_y),
		.shear_q8(shear_q8),
		.pixel_value(pixel_value),
		.cmd(cmd_front)
	);

	sefs_fifo #(
		.WIDTH(CMD_W)
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push),
		.wr_data(cmd_front),
		.full(full),
		.rd_en(cmd_pop),
		.rd_data(cmd_head_vec),
		.empty(cmd_empty)
	);

	assign cmd_head = sefs_pkg::cmd_t'(cmd_head_vec);

	sefs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_avail(!cmd_empty),
		.cmd(cmd_head),
		.cmd_pop(cmd_pop),
		.canvas(canvas),
		.span_full(span_full),
		.span_push(span_push),
		.span(span_back)
	);

	sefs_fifo #(
		.WIDTH(SPAN_W)
	) u_span_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(span_push),
		.wr_data(span_back),
		.full(span_full),
		.rd_en(pop),
		.rd_data(span_head_vec),
		.empty(empty)
	);

	assign span_head  = sefs_pkg::span_t'(span_head_vec);
	assign row_y      = span_head.row;
	assign span_start = span_head.lo;
	assign span_end   = span_head.hi;
	assign span_valid = span_head.valid;
	assign span_value = span_head.value;
	assign last_span  = span_head.last;

	assign span_on_canvas = (11'(span_end) < canvas.width) && (11'(row_y) < canvas.height);
	assign span_clear     = (row_y == 10'd0) && (span_start == 10'd0) && (span_end == 10'd0)
		&& !span_value;

	`SEFS_ASSERT_IMPL(a_span_order, clk, arst_n, !empty && span_valid, span_start <= span_end)
	`SEFS_ASSERT_IMPL(a_span_on_canvas, clk, arst_n, !empty && span_valid, span_on_canvas)
	`SEFS_ASSERT_IMPL(a_hidden_span_clear, clk, arst_n, !empty && !span_valid, span_clear)

endmodule
`default_nettype wire

// ===== hw/rtl/sefs_fifo.sv =====
// Two-entry queue used between front, back and result port.
`timescale 1ns / 1ps
`default_nettype none
module sefs_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sefs_front.sv =====
// Front end: classifies a fill command and squares its radii.
`timescale 1ns / 1ps
`default_nettype none
module sefs_front #(
	parameter int MAX_RADIUS = sefs_pkg::MAX_RADIUS_DEF
) (
	input  wire logic signed [11:0] center_x,
	input  wire logic signed [11:0] center_y,
	input  wire logic signed [7:0]  radius_x,
	input  wire logic signed [5:0]  radius_y,
	input  wire logic signed [8:0]  shear_q8,
	input  wire logic               pixel_value,
	output sefs_pkg::cmd_t          cmd
);

	localparam logic [4:0] RY_MAX = 5'(MAX_RADIUS);

	logic       rx_pos;
	logic       ry_pos;
	logic [4:0] ry_sat;
	logic [6:0] rx_mag;

	always_comb begin
		rx_pos = !radius_x[7] && (radius_x != 8'sd0);
		ry_pos = !radius_y[5] && (radius_y != 6'sd0);
		rx_mag = radius_x[6:0];
		ry_sat = (radius_y[4:0] > RY_MAX) ? RY_MAX : radius_y[4:0];

		cmd.degen = !(rx_pos && ry_pos);
		cmd.cx    = center_x;
		cmd.cy    = center_y;
		cmd.ry    = ry_sat;
		cmd.ry2   = 10'(ry_sat) * 10'(ry_sat);
		cmd.rx2   = 14'(rx_mag) * 14'(rx_mag);
		cmd.sh    = shear_q8;
		cmd.val   = pixel_value;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sefs_back.sv =====
// Back end: walks the rows, searches each half-width bit by bit, shifts and clips.
`timescale 1ns / 1ps
`default_nettype none
module sefs_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_avail,
	input  wire sefs_pkg::cmd_t    cmd,
	output logic                   cmd_pop,
	input  wire sefs_pkg::canvas_t canvas,
	input  wire logic              span_full,
	output logic                   span_push,
	output sefs_pkg::span_t        span
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SEARCH,
		ST_SHIFT,
		ST_EMIT,
		ST_DEGEN
	} state_t;

	state_t                       state_q;
	sefs_pkg::cmd_t               cmd_q;
	logic signed [5:0]            y_q;
	logic [9:0]                   yy_q;
	logic [23:0]                  rhs_q;
	logic signed [14:0]           ysh_q;
	logic [sefs_pkg::HW_BITS-1:0] hw_q;
	logic [23:0]                  p_q;
	logic [16:0]                  q_q;
	logic [2:0]                   k_q;
	logic signed [13:0]           lo_q;
	logic signed [13:0]           hi_q;
	logic signed [12:0]           py_q;

	logic [25:0]        t_sum;
	logic               hit;
	logic signed [16:0] num;
	logic signed [16:0] xs_full;
	logic signed [7:0]  xs;
	logic signed [13:0] hw_s;
	logic signed [13:0] lo_raw;
	logic signed [13:0] hi_raw;
	logic signed [12:0] py_raw;
	logic signed [13:0] lo_c;
	logic signed [13:0] hi_c;
	logic signed [13:0] wm1;
	logic               ok;
	logic               last_row;

	// candidate square times ry2, built from the accepted bits by shifts and adds
	always_comb begin
		t_sum = 26'(p_q) + (26'(q_q) << (k_q + 3'd1)) + (26'(cmd_q.ry2) << {k_q, 1'b0});
		hit   = (t_sum <= 26'(rhs_q));
	end

	// shift offset by a half toward the sign of y, then truncated toward zero
	always_comb begin
		num     = -(17'(ysh_q) <<< 1) + (y_q[5] ? -17'sd256 : 17'sd256);
		xs_full = num[16] ? ((num + 17'sd511) >>> 9) : (num >>> 9);
		xs      = xs_full[7:0];
		hw_s    = $signed({7'b0, hw_q});
		lo_raw  = 14'(cmd_q.cx) + 14'(xs) - hw_s;
		hi_raw  = 14'(cmd_q.cx) + 14'(xs) + hw_s;
		py_raw  = 13'(cmd_q.cy) + 13'(y_q);
	end

	always_comb begin
		wm1      = $signed({3'b000, canvas.width}) - 14'sd1;
		lo_c     = lo_q[13] ? 14'sd0 : lo_q;
		hi_c     = (hi_q > wm1) ? wm1 : hi_q;
		ok       = !py_q[12] && (py_q < $signed({2'b00, canvas.height}))
			&& (canvas.width != 11'd0) && (lo_c <= hi_c);
		last_row = (y_q == $signed({1'b0, cmd_q.ry}));

		cmd_pop   = (state_q == ST_IDLE) && cmd_avail;
		span_push = ((state_q == ST_EMIT) || (state_q == ST_DEGEN)) && !span_full;

		span = '0;
		if (state_q == ST_DEGEN) begin
			span.last = 1'b1;
		end else begin
			span.last = last_row;
			if (ok) begin
				span.row   = py_q[9:0];
				span.lo    = lo_c[9:0];
				span.hi    = hi_c[9:0];
				span.valid = 1'b1;
				span.value = cmd_q.val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_avail) begin
						cmd_q <= cmd;
						y_q   <= -$signed({1'b0, cmd.ry});
						yy_q  <= cmd.ry2;
						state_q <= cmd.degen ? ST_DEGEN : ST_SETUP;
					end
				end
				ST_SETUP: begin
					rhs_q   <= 24'(cmd_q.rx2) * 24'(cmd_q.ry2 - yy_q);
					ysh_q   <= 15'(y_q) * 15'(cmd_q.sh);
					hw_q    <= '0;
					p_q     <= '0;
					q_q     <= '0;
					k_q     <= 3'(sefs_pkg::HW_BITS - 1);
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (hit) begin
						hw_q[k_q] <= 1'b1;
						p_q       <= t_sum[23:0];
						q_q       <= q_q + (17'(cmd_q.ry2) << k_q);
					end
					if (k_q == 3'd0) begin
						state_q <= ST_SHIFT;
					end else begin
						k_q <= k_q - 3'd1;
					end
				end
				ST_SHIFT: begin
					lo_q    <= lo_raw;
					hi_q    <= hi_raw;
					py_q    <= py_raw;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!span_full) begin
						if (last_row) begin
							state_q <= ST_IDLE;
						end else begin
							y_q     <= y_q + 6'sd1;
							yy_q    <= 10'({2'b00, yy_q} + {{5{y_q[5]}}, y_q, 1'b1});
							state_q <= ST_SETUP;
						end
					end
				end
				ST_DEGEN: begin
					if (!span_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
